/* src/srrb_pkg.sv */
package srrb_pkg;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [12:0] record_length;
    logic [7:0]  data_byte;
    logic [63:0] seq_value;
    logic [5:0]  entry_index;
    logic [11:0] byte_offset;
    logic [11:0] byte_position;
  } in_item_t;

  typedef struct packed {
    logic [63:0] record_seq;
    logic        found;
    logic [12:0] found_length;
    logic [11:0] found_offset;
    logic [7:0]  read_data;
    logic [31:0] dropped_count;
    logic [63:0] acked_seq;
    logic [6:0]  pending_count;
    logic [12:0] bytes_used;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_APPEND_BEGIN = 3'd0,
    CMD_APPEND_BYTE  = 3'd1,
    CMD_ACK          = 3'd2,
    CMD_FIND         = 3'd3,
    CMD_READ         = 3'd4
  } cmd_t;

  localparam logic CFG_SLOT_LIMIT = 1'b0;
  localparam logic CFG_BYTE_LIMIT = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_REJECT,
    OP_EVICT,
    OP_ALLOC,
    OP_WRITE_BYTE,
    OP_ACK_FREE,
    OP_ACK_DONE,
    OP_FIND_LOOK,
    OP_FIND_DONE,
    OP_READ_MOD,
    OP_READ_ADDR,
    OP_READ_DONE,
    OP_STATUS
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic reject;
    logic need_evict;
    logic ack_more;
    logic mod_last;
  } dp_stat_t;

endpackage

/* src/sequenced_record_ring_buffer.sv */
// Append byte, rejected append and unknown commands go straight to the status
// step; append begin and ack re-read the slot memory for each evicted or freed
// record (single read port of the slot memory); read first reduces the byte
// address modulo the byte limit by restoring steps. One item in flight: the
// next item can be taken in the same cycle as the result leaves.
// Reset (synchronous, rst_n low) empties the ring and clears sequences, drop
// counter and limits to their defaults; record memories are not cleared.
module sequenced_record_ring_buffer import srrb_pkg::*; #(
  parameter int SLOT_DEPTH = 64,
  parameter int BYTE_DEPTH = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [12:0] cfg_data
);
  dp_cmd_t  dcmd;
  dp_stat_t stat;

  srrb_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd(in_data.cmd),
    .out_valid, .out_ready, .cfg_valid, .cfg_ready, .stat, .dcmd
  );

  srrb_datapath #(.SLOT_DEPTH(SLOT_DEPTH), .BYTE_DEPTH(BYTE_DEPTH)) u_dp (
    .clk, .rst_n, .cfg_we(cfg_valid && cfg_ready), .cfg_sel(cfg_index[0]),
    .cfg_data, .item(in_data), .dcmd, .stat, .result(out_data)
  );
endmodule

/* src/srrb_datapath.sv */
module srrb_datapath import srrb_pkg::*; #(
  parameter int SLOT_DEPTH = 64,
  parameter int BYTE_DEPTH = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_sel,
  input  logic [12:0] cfg_data,
  input  in_item_t  item,
  input  dp_cmd_t   dcmd,
  output dp_stat_t  stat,
  output out_item_t result
);
  localparam int SW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int BW = $clog2(BYTE_DEPTH);

  logic [63:0] seq_mem [SLOT_DEPTH];
  logic [12:0] len_mem [SLOT_DEPTH];
  logic [11:0] start_mem [SLOT_DEPTH];
  logic [7:0]  byte_mem [BYTE_DEPTH];

  logic [6:0]  slot_limit_r;
  logic [12:0] byte_limit_r;
  logic [SW-1:0] head_r;
  logic [10:0] count_r;
  logic [16:0] used_r;
  logic [16:0] wpos_r;
  logic [63:0] last_r, acked_r;
  logic [31:0] drop_r;
  logic [16:0] remain_r;
  in_item_t    it_r;
  logic [63:0] seq_clamp_r;
  logic [63:0] rd_seq_r;
  logic [12:0] rd_len_r;
  logic [11:0] rd_start_r;
  logic [7:0]  rd_byte_r;
  logic [SW-1:0] rd_addr_r;
  logic [BW-1:0] baddr_r;
  logic [63:0] skip_r;
  logic        skip_ok_r;
  logic [12:0] rem_r;
  logic [3:0]  mstep_r;
  out_item_t   res_r;

  logic [10:0] ns;
  logic [16:0] nb;
  logic [SW-1:0] head_inc;
  logic [10:0] tail_sum;
  logic [SW-1:0] tail_slot;
  logic [16:0] len17;
  logic [16:0] wsum, wnext;
  logic [16:0] waddr;
  logic [25:0] mod_sub;
  logic [63:0] first_seq;
  logic [10:0] fsum;
  logic [SW-1:0] fslot;
  logic [16:0] len_free;

  always_comb begin
    if (slot_limit_r == 7'd0) ns = 11'd1;
    else if (32'(slot_limit_r) > SLOT_DEPTH) ns = 11'(SLOT_DEPTH);
    else ns = 11'(slot_limit_r);
    if (byte_limit_r == 13'd0) nb = 17'd1;
    else if (32'(byte_limit_r) > BYTE_DEPTH) nb = 17'(BYTE_DEPTH);
    else nb = 17'(byte_limit_r);
    head_inc = (11'(head_r) + 11'd1 >= ns) ? '0 : SW'(11'(head_r) + 11'd1);
    tail_sum = 11'(head_r) + count_r;
    tail_slot = (tail_sum >= ns) ? SW'(tail_sum - ns) : SW'(tail_sum);
    len17 = 17'(it_r.record_length);
    wsum = wpos_r + len17;
    wnext = (wsum >= nb) ? wsum - nb : wsum;
    waddr = (wpos_r >= remain_r) ? wpos_r - remain_r : wpos_r + nb - remain_r;
    // one restoring step of (offset + position) mod byte limit
    mod_sub = 26'(nb) << mstep_r;
    first_seq = rd_seq_r;
    fsum = 11'(head_r) + 11'(skip_r[10:0]) + 11'(it_r.entry_index);
    fslot = (fsum >= ns) ? ((fsum - ns >= ns) ? SW'(fsum - ns - ns) : SW'(fsum - ns))
                         : SW'(fsum);
    len_free = (17'(rd_len_r) > used_r) ? 17'd0 : used_r - 17'(rd_len_r);
    stat.reject = (it_r.record_length == 13'd0) || (len17 > nb) || (&last_r);
    stat.need_evict = (count_r != 0) &&
                      ((count_r >= ns) || (nb - used_r < len17));
    stat.ack_more = (count_r != 0) && (rd_seq_r <= seq_clamp_r);
    stat.mod_last = (mstep_r == 4'd0);
  end

  always_ff @(posedge clk) begin
    rd_seq_r <= seq_mem[rd_addr_r];
    rd_len_r <= len_mem[rd_addr_r];
    rd_start_r <= start_mem[rd_addr_r];
    rd_byte_r <= byte_mem[baddr_r];
    if (dcmd.op == OP_ALLOC) begin
      seq_mem[tail_slot] <= last_r + 64'd1;
      len_mem[tail_slot] <= it_r.record_length;
      start_mem[tail_slot] <= wpos_r[11:0];
    end
    if (dcmd.op == OP_WRITE_BYTE && remain_r != 0)
      byte_mem[BW'(waddr)] <= it_r.data_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_limit_r <= 7'd64;
      byte_limit_r <= 13'd4096;
      head_r <= '0;
      count_r <= '0;
      used_r <= '0;
      wpos_r <= '0;
      last_r <= '0;
      acked_r <= '0;
      drop_r <= '0;
      remain_r <= '0;
      rd_addr_r <= '0;
      baddr_r <= '0;
    end else if (cfg_we) begin
      if (cfg_sel == CFG_SLOT_LIMIT) slot_limit_r <= cfg_data[6:0];
      else byte_limit_r <= cfg_data;
      head_r <= '0;
      count_r <= '0;
      used_r <= '0;
      wpos_r <= '0;
      remain_r <= '0;
      rd_addr_r <= '0;
    end else begin
      case (dcmd.op)
        OP_LOAD: begin
          it_r <= item;
          seq_clamp_r <= (item.seq_value > last_r) ? last_r : item.seq_value;
          rd_addr_r <= head_r;
          rem_r <= 13'(item.byte_offset) + 13'(item.byte_position);
          mstep_r <= 4'd12;
          if (item.cmd == CMD_APPEND_BEGIN) remain_r <= '0;
        end
        OP_REJECT: if (drop_r != '1) drop_r <= drop_r + 32'd1;
        OP_EVICT: begin
          used_r <= len_free;
          head_r <= head_inc;
          rd_addr_r <= head_inc;
          count_r <= count_r - 11'd1;
          if (drop_r != '1) drop_r <= drop_r + 32'd1;
        end
        OP_ALLOC: begin
          last_r <= last_r + 64'd1;
          wpos_r <= wnext;
          used_r <= used_r + len17;
          count_r <= count_r + 11'd1;
          remain_r <= len17;
        end
        OP_WRITE_BYTE: if (remain_r != 0) remain_r <= remain_r - 17'd1;
        OP_ACK_FREE: begin
          used_r <= len_free;
          head_r <= head_inc;
          rd_addr_r <= head_inc;
          count_r <= count_r - 11'd1;
        end
        OP_ACK_DONE: if (seq_clamp_r > acked_r) acked_r <= seq_clamp_r;
        OP_FIND_LOOK: begin
          skip_r <= (it_r.seq_value < first_seq) ? 64'd0
                                                 : it_r.seq_value - first_seq + 64'd1;
        end
        OP_FIND_DONE: begin
          rd_addr_r <= fslot;
        end
        OP_READ_MOD: begin
          if (mod_sub <= 26'(rem_r)) rem_r <= rem_r - 13'(mod_sub);
          if (mstep_r != 4'd0) mstep_r <= mstep_r - 4'd1;
        end
        OP_READ_ADDR: begin
          baddr_r <= BW'(rem_r);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (dcmd.op == OP_FIND_DONE)
      skip_ok_r <= (count_r != 0) && (it_r.seq_value < last_r) &&
                   (skip_r < 64'(count_r)) &&
                   (11'(it_r.entry_index) < count_r - 11'(skip_r[10:0]));
    if (dcmd.op == OP_STATUS) begin
      res_r <= '0;
      if (it_r.cmd == CMD_APPEND_BEGIN && !(stat.reject && remain_r == 0))
        res_r.record_seq <= last_r;
      if (it_r.cmd == CMD_FIND && skip_ok_r) begin
        res_r.record_seq <= rd_seq_r;
        res_r.found <= 1'b1;
        res_r.found_length <= rd_len_r;
        res_r.found_offset <= rd_start_r;
      end
      if (it_r.cmd == CMD_READ) res_r.read_data <= rd_byte_r;
      res_r.dropped_count <= drop_r;
      res_r.acked_seq <= acked_r;
      res_r.pending_count <= 7'(count_r);
      res_r.bytes_used <= 13'(used_r);
    end
  end

  assign result = res_r;
endmodule

/* src/srrb_ctrl.sv */
module srrb_ctrl import srrb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic [2:0] in_cmd,
  output logic     out_valid,
  input  logic     out_ready,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  dcmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_EVICT_RD, S_EVICT, S_ACK_RD, S_ACK,
    S_FIND_RD, S_FIND_SKIP, S_FIND_SLOT, S_FIND_WAIT, S_READ_MOD, S_READ_RD,
    S_READ_WAIT, S_STATUS, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic [2:0] cmd_r;
  logic       out_valid_r;

  // a pending config write goes first
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    dcmd.op = OP_NONE;
    case (state_r)
      S_IDLE: if (in_valid && in_ready) begin
        dcmd.op = OP_LOAD;
        state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (cmd_r)
          CMD_APPEND_BEGIN: begin
            if (stat.reject) begin
              dcmd.op = OP_REJECT;
              state_nxt = S_STATUS;
            end else state_nxt = S_EVICT_RD;
          end
          CMD_APPEND_BYTE: begin
            dcmd.op = OP_WRITE_BYTE;
            state_nxt = S_STATUS;
          end
          CMD_ACK: state_nxt = S_ACK_RD;
          CMD_FIND: state_nxt = S_FIND_RD;
          CMD_READ: state_nxt = S_READ_MOD;
          default: state_nxt = S_STATUS;
        endcase
      end
      S_EVICT_RD: state_nxt = S_EVICT;
      S_EVICT: begin
        if (stat.need_evict) begin
          dcmd.op = OP_EVICT;
          state_nxt = S_EVICT_RD;
        end else begin
          dcmd.op = OP_ALLOC;
          state_nxt = S_STATUS;
        end
      end
      S_ACK_RD: state_nxt = S_ACK;
      S_ACK: begin
        if (stat.ack_more) begin
          dcmd.op = OP_ACK_FREE;
          state_nxt = S_ACK_RD;
        end else begin
          dcmd.op = OP_ACK_DONE;
          state_nxt = S_STATUS;
        end
      end
      S_FIND_RD: state_nxt = S_FIND_SKIP;
      S_FIND_SKIP: begin
        dcmd.op = OP_FIND_LOOK;
        state_nxt = S_FIND_SLOT;
      end
      S_FIND_SLOT: begin
        dcmd.op = OP_FIND_DONE;
        state_nxt = S_FIND_WAIT;
      end
      S_FIND_WAIT: state_nxt = S_READ_WAIT;
      S_READ_MOD: begin
        dcmd.op = OP_READ_MOD;
        if (stat.mod_last) state_nxt = S_READ_RD;
      end
      S_READ_RD: begin
        dcmd.op = OP_READ_ADDR;
        state_nxt = S_READ_WAIT;
      end
      S_READ_WAIT: state_nxt = S_STATUS;
      S_STATUS: begin
        dcmd.op = OP_STATUS;
        state_nxt = S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      cmd_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE && in_valid && in_ready) cmd_r <= in_cmd;
      if (state_r == S_OUT) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end
endmodule

/* src/srrb_checker.sv */
module srrb_checker import srrb_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data,
  input logic      cfg_valid,
  input logic      cfg_ready
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !out_valid)
    else $error("config taken with result pending");
  a_cfg_alone: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> !(in_valid && in_ready))
    else $error("config and item taken together");
  a_found_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.record_seq != 64'd0)
    else $error("found record with zero sequence");
endmodule

bind sequenced_record_ring_buffer srrb_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_data, .cfg_valid, .cfg_ready
);

/* dv/sequenced_record_ring_buffer_tb.sv */
`timescale 1ns / 1ps

module sequenced_record_ring_buffer_tb;
  import srrb_pkg::*;

  class ring_shadow;
    bit [63:0] seq_mem[64];
    int        len_mem[64];
    int        start_mem[64];
    bit [7:0]  store[4096];
    bit        written[4096];
    int        head, count, used, wpos, remaining;
    bit [63:0] last_seq, acked;
    bit [31:0] drops;
    int        slot_lim, byte_lim;
    int        errors;
    out_item_t expected_results[$];

    function new();
      slot_lim = 64;
      byte_lim = 4096;
    endfunction

    function int ns();
      if (slot_lim == 0) return 1;
      return slot_lim > 64 ? 64 : slot_lim;
    endfunction

    function int nb();
      if (byte_lim == 0) return 1;
      return byte_lim > 4096 ? 4096 : byte_lim;
    endfunction

    function void empty_ring();
      head = 0;
      count = 0;
      used = 0;
      wpos = 0;
      remaining = 0;
    endfunction

    function void count_drop();
      if (drops != 32'hFFFF_FFFF) drops++;
    endfunction

    function void free_oldest();
      used = len_mem[head] > used ? 0 : used - len_mem[head];
      head = (head + 1) % ns();
      count--;
    endfunction

    function void configure(logic [0:0] idx, logic [12:0] val);
      if (idx == CFG_SLOT_LIMIT) slot_lim = val & 13'h7F;
      else byte_lim = val;
      empty_ring();
    endfunction

    function void note_item(in_item_t it);
      out_item_t r;
      bit [63:0] s, first, skip;
      int        k, slot, addr, len;
      r = '0;
      len = it.record_length;
      case (it.cmd)
        CMD_APPEND_BEGIN: begin
          remaining = 0;
          if (len == 0 || len > nb() || last_seq == '1) begin
            count_drop();
          end else begin
            for (k = 0; k <= 64 && count > 0 && (count >= ns() || nb() - used < len); k++) begin
              free_oldest();
              count_drop();
            end
            slot = (head + count) % ns();
            last_seq++;
            seq_mem[slot] = last_seq;
            len_mem[slot] = len;
            start_mem[slot] = wpos;
            wpos = (wpos + len) % nb();
            used += len;
            count++;
            remaining = len;
            r.record_seq = last_seq;
          end
        end
        CMD_APPEND_BYTE: begin
          if (remaining > 0) begin
            addr = (wpos + nb() - remaining) % nb();
            store[addr] = it.data_byte;
            written[addr] = 1;
            remaining--;
          end
        end
        CMD_ACK: begin
          s = it.seq_value;
          if (s > last_seq) s = last_seq;
          for (k = 0; k < 64 && count > 0 && seq_mem[head] <= s; k++) free_oldest();
          if (s > acked) acked = s;
        end
        CMD_FIND: begin
          s = it.seq_value;
          if (count > 0 && s < last_seq) begin
            first = seq_mem[head];
            skip = s < first ? 64'd0 : s - first + 1;
            if (skip < count && it.entry_index < count - skip) begin
              slot = (head + int'(skip) + it.entry_index) % ns();
              r.record_seq = seq_mem[slot];
              r.found = 1'b1;
              r.found_length = 13'(len_mem[slot]);
              r.found_offset = 12'(start_mem[slot]);
            end
          end
        end
        CMD_READ: r.read_data = store[(it.byte_offset + it.byte_position) % nb()];
        default: ;
      endcase
      r.dropped_count = drops;
      r.acked_seq = acked;
      r.pending_count = 7'(count);
      r.bytes_used = 13'(used);
      expected_results.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t e;
      if (expected_results.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      e = expected_results.pop_front();
      if (got.record_seq != e.record_seq)
        report($sformatf("record_seq %0h exp %0h", got.record_seq, e.record_seq));
      if (got.found != e.found)
        report($sformatf("found %0d exp %0d", got.found, e.found));
      if (got.found_length != e.found_length)
        report($sformatf("found_length %0d exp %0d", got.found_length, e.found_length));
      if (got.found_offset != e.found_offset)
        report($sformatf("found_offset %0d exp %0d", got.found_offset, e.found_offset));
      if (got.read_data != e.read_data)
        report($sformatf("read_data %0h exp %0h", got.read_data, e.read_data));
      if (got.dropped_count != e.dropped_count)
        report($sformatf("dropped_count %0d exp %0d", got.dropped_count, e.dropped_count));
      if (got.acked_seq != e.acked_seq)
        report($sformatf("acked_seq %0h exp %0h", got.acked_seq, e.acked_seq));
      if (got.pending_count != e.pending_count)
        report($sformatf("pending_count %0d exp %0d", got.pending_count, e.pending_count));
      if (got.bytes_used != e.bytes_used)
        report($sformatf("bytes_used %0d exp %0d", got.bytes_used, e.bytes_used));
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 0;
  out_item_t   out_data;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = CFG_SLOT_LIMIT;
  logic [12:0] cfg_data = '0;

  ring_shadow sb = new();
  int idle_in, idle_out;
  int hold_left, hold_req;

  sequenced_record_ring_buffer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= idle_out;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  task send_item(in_item_t it);
    while ($urandom_range(99) < idle_in) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    @(negedge clk);
  endtask

  task wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task write_limits(logic [12:0] slots, logic [12:0] bytes);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SLOT_LIMIT;
    cfg_data <= slots;
    do @(posedge clk); while (!cfg_ready);
    sb.configure(CFG_SLOT_LIMIT, slots);
    @(negedge clk);
    cfg_index <= CFG_BYTE_LIMIT;
    cfg_data <= bytes;
    do @(posedge clk); while (!cfg_ready);
    sb.configure(CFG_BYTE_LIMIT, bytes);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t noise_item();
    in_item_t it;
    it.cmd = 3'($urandom);
    it.record_length = 13'($urandom);
    it.data_byte = 8'($urandom);
    it.seq_value = {$urandom, $urandom};
    it.entry_index = 6'($urandom);
    it.byte_offset = 12'($urandom);
    it.byte_position = 12'($urandom);
    return it;
  endfunction

  function automatic in_item_t cmd_item(cmd_t c, int len, int data, bit [63:0] s, int idx,
                                        int off, int pos);
    in_item_t it;
    it = noise_item();
    it.cmd = c;
    it.record_length = 13'(len);
    it.data_byte = 8'(data);
    it.seq_value = s;
    it.entry_index = 6'(idx);
    it.byte_offset = 12'(off);
    it.byte_position = 12'(pos);
    return it;
  endfunction

  // Picks a byte address already written below the current byte limit, or -1.
  function automatic int pick_written();
    int a, n, t;
    n = sb.nb();
    for (t = 0; t < 24; t++) begin
      if (t < 12) a = (sb.wpos + n - $urandom_range(1, n < 64 ? n : 64)) % n;
      else a = $urandom_range(n - 1);
      if (sb.written[a]) return a;
    end
    return -1;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int r, n, a, off, cnt;
    bit [63:0] base;
    it = noise_item();
    n = sb.nb();
    cnt = sb.count;
    base = cnt > 0 ? sb.seq_mem[sb.head] - 1 : sb.last_seq;
    if (sb.remaining > 0 && $urandom_range(99) < 85) begin
      it.cmd = CMD_APPEND_BYTE;
      return it;
    end
    r = $urandom_range(99);
    if (r < 35) begin
      it.cmd = CMD_APPEND_BEGIN;
      a = $urandom_range(99);
      if (a < 80) it.record_length = 13'($urandom_range(1, n < 12 ? n : 12));
      else if (a < 90) it.record_length = 13'($urandom_range(1, n));
      else if (a < 95) it.record_length = 0;
      else it.record_length = 13'($urandom_range(n + 1, 8191));
    end else if (r < 43) begin
      it.cmd = CMD_APPEND_BYTE;
    end else if (r < 58) begin
      it.cmd = CMD_ACK;
      if ($urandom_range(99) >= 10) it.seq_value = base + $urandom_range(0, cnt + 1);
    end else if (r < 77) begin
      it.cmd = CMD_FIND;
      if ($urandom_range(99) >= 10) it.seq_value = base + $urandom_range(0, cnt + 1);
      if ($urandom_range(99) < 70) it.entry_index = 6'($urandom_range(0, cnt + 1));
    end else if (r < 97) begin
      a = pick_written();
      if (a < 0) begin
        it.cmd = CMD_FIND;
      end else begin
        it.cmd = CMD_READ;
        off = it.byte_offset;
        it.byte_position = 12'((a + n - off % n) % n);
      end
    end else begin
      it.cmd = 3'($urandom_range(5, 7));
    end
    return it;
  endfunction

  initial begin
    int ph, i;
    int slot_set[6] = '{4, 1, 127, 0, 16, 64};
    int byte_set[6] = '{64, 1, 8191, 0, 200, 4096};
    idle_in = 30;
    idle_out = 77;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(cmd_item(CMD_APPEND_BYTE, 0, 8'h5A, 0, 0, 0, 0));
    send_item(cmd_item(CMD_APPEND_BEGIN, 0, 0, 0, 0, 0, 0));
    send_item(cmd_item(CMD_APPEND_BEGIN, 8191, 0, 0, 0, 0, 0));
    send_item(cmd_item(CMD_APPEND_BEGIN, 3, 0, 0, 0, 0, 0));
    send_item(cmd_item(CMD_APPEND_BYTE, 0, 8'h00, 0, 0, 0, 0));
    send_item(cmd_item(CMD_APPEND_BYTE, 0, 8'hFF, 0, 0, 0, 0));
    send_item(cmd_item(CMD_APPEND_BYTE, 0, 8'hA5, 0, 0, 0, 0));
    send_item(cmd_item(CMD_APPEND_BEGIN, 4096, 0, 0, 0, 0, 0));
    send_item(cmd_item(CMD_APPEND_BYTE, 0, 8'h3C, 0, 0, 0, 0));
    send_item(cmd_item(CMD_APPEND_BEGIN, 2, 0, 0, 0, 0, 0));
    send_item(cmd_item(CMD_APPEND_BYTE, 0, 8'h81, 0, 0, 0, 0));
    send_item(cmd_item(CMD_APPEND_BYTE, 0, 8'h7E, 0, 0, 0, 0));
    send_item(cmd_item(CMD_READ, 0, 0, 0, 0, 4095, 1));
    send_item(cmd_item(CMD_READ, 0, 0, 0, 0, 2, 0));
    send_item(cmd_item(CMD_READ, 0, 0, 0, 0, 0, 4));
    send_item(cmd_item(CMD_FIND, 0, 0, 0, 0, 0, 0));
    send_item(cmd_item(CMD_FIND, 0, 0, 0, 63, 0, 0));
    send_item(cmd_item(CMD_APPEND_BEGIN, 5, 0, 0, 0, 0, 0));
    send_item(cmd_item(CMD_FIND, 0, 0, 64'd3, 0, 0, 0));
    send_item(cmd_item(CMD_ACK, 0, 0, '1, 0, 0, 0));
    send_item(cmd_item(CMD_FIND, 0, 0, 0, 0, 0, 0));
    send_item(cmd_item(cmd_t'(3'd5), 0, 0, 0, 0, 0, 0));
    send_item(cmd_item(cmd_t'(3'd7), 0, 0, 0, 0, 0, 0));
    wait_idle();

    for (ph = 0; ph < 6; ph++) begin
      idle_in = ph < 2 ? 30 : (ph < 4 ? 77 : 0);
      idle_out = ph < 2 ? 77 : (ph < 4 ? 30 : 0);
      write_limits(13'(slot_set[ph]), 13'(byte_set[ph]));
      for (i = 0; i < 190; i++) begin
        if (ph == 0 && i == 20) hold_req = 400;
        if (ph == 4 && i == 95) wait_idle();
        send_item(random_item());
      end
      wait_idle();
    end

    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
